// File: sv/rtpst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpst_pkg: RTP sequence tracker shared types
// Item and result beat layouts, status codes and configuration indexes.
// ----------------------------------------------------------------------------
package rtpst_pkg;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_PACKET = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_PROBATION = 3'd0,
    ST_VALID     = 3'd1,
    ST_IN_ORDER  = 3'd2,
    ST_RESYNC    = 3'd3,
    ST_JUMP      = 3'd4,
    ST_REORDER   = 3'd5,
    ST_STARTED   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CFG_MIN_SEQUENTIAL = 2'd0,
    CFG_MAX_DROPOUT    = 2'd1,
    CFG_MAX_MISORDER   = 2'd2
  } cfg_index_t;

  localparam logic [7:0]  MIN_SEQUENTIAL_RST = 8'd2;
  localparam logic [15:0] MAX_DROPOUT_RST    = 16'd3000;
  localparam logic [15:0] MAX_MISORDER_RST   = 16'd100;

  typedef struct packed {
    op_t         op;
    logic [15:0] seq;
  } item_t;

  typedef struct packed {
    logic        accepted;
    status_t     status;
    logic [31:0] ext_highest_seq;
    logic [31:0] received_count;
    logic [15:0] base_sequence;
  } result_t;

endpackage

`default_nettype wire

// File: sv/rtpst_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpst_fifo: small synchronous queue
// Register-based queue; push and pop may complete in the same cycle.
// ----------------------------------------------------------------------------
module rtpst_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push_ok && !pop_ok) begin
        cnt <= cnt + CW'(1);
      end else if (pop_ok && !push_ok) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/rtpst_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpst_front: input side of the sequence tracker
// Accepts input beats, decodes the command and queues items for the core.
// ----------------------------------------------------------------------------
module rtpst_front
  import rtpst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [15:0] seq,
  output logic             item_valid,
  output item_t            item,
  input  wire logic        item_take
);

  item_t item_in;
  logic  q_empty;

  always_comb begin
    item_in.op  = cmd ? OP_PACKET : OP_START;
    item_in.seq = seq;
  end

  rtpst_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (2)
  ) u_inq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (item_in),
    .full  (full),
    .pop   (item_take),
    .rdata (item),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;

endmodule

`default_nettype wire

// File: sv/rtpst_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtpst_core: sequence validation engine
// Holds per-source state and config; runs one item per cycle while !res_full.
// ----------------------------------------------------------------------------
module rtpst_core
  import rtpst_pkg::*;
#(
  parameter int SEQ_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        item_valid,
  input  wire item_t       item,
  output logic             item_take,
  output logic             res_push,
  output result_t          res,
  input  wire logic        res_full
);

  localparam int SB = SEQ_BITS;
  localparam int CW = ((SB > 16) ? SB : 16) + 2;
  localparam logic [SB:0]   EBS_NEVER = {1'b1, {(SB - 1){1'b0}}, 1'b1};
  localparam logic [SB:0]   ONE_W     = (SB + 1)'(1);
  localparam logic [CW-1:0] SEQ_MOD_W = CW'({1'b1, {SB{1'b0}}});

  logic [7:0]  min_sequential;
  logic [15:0] max_dropout;
  logic [15:0] max_misorder;

  logic [7:0]    prob, prob_next;
  logic [SB-1:0] hs, hs_next;
  logic [SB:0]   ebs, ebs_next;
  logic [15:0]   wrap, wrap_next;
  logic [31:0]   rcv, rcv_next;
  logic [15:0]   base, base_next;

  logic [SB-1:0] s;
  logic [SB-1:0] s_inc;
  logic [SB-1:0] udelta;
  logic          in_step;
  logic          near;
  logic          jump_zone;
  logic          acc;
  status_t       status;

  assign item_take = item_valid && !res_full;
  assign res_push  = item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sequential <= MIN_SEQUENTIAL_RST;
      max_dropout    <= MAX_DROPOUT_RST;
      max_misorder   <= MAX_MISORDER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_SEQUENTIAL: min_sequential <= cfg_data[7:0];
        CFG_MAX_DROPOUT:    max_dropout    <= cfg_data;
        CFG_MAX_MISORDER:   max_misorder   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    s         = SB'(item.seq);
    s_inc     = s + SB'(1);
    udelta    = s - hs;
    in_step   = ({1'b0, s} == ({1'b0, hs} + ONE_W));
    near      = (CW'(udelta) < CW'(max_dropout));
    jump_zone = ((CW'(udelta) + CW'(max_misorder)) <= SEQ_MOD_W);

    prob_next = prob;
    hs_next   = hs;
    ebs_next  = ebs;
    wrap_next = wrap;
    rcv_next  = rcv;
    base_next = base;
    acc       = 1'b0;
    status    = ST_STARTED;

    if (item.op == OP_START) begin
      base_next = 16'(s);
      hs_next   = s - SB'(1);
      ebs_next  = EBS_NEVER;
      wrap_next = '0;
      rcv_next  = '0;
      prob_next = min_sequential;
      status    = ST_STARTED;
    end else if (prob != '0) begin
      hs_next = s;
      status  = ST_PROBATION;
      if (in_step) begin
        prob_next = prob - 8'd1;
        if (prob == 8'd1) begin
          base_next = 16'(s);
          ebs_next  = EBS_NEVER;
          wrap_next = '0;
          rcv_next  = 32'd1;
          acc       = 1'b1;
          status    = ST_VALID;
        end
      end else begin
        prob_next = min_sequential - 8'd1;
      end
    end else if (near) begin
      if (s < hs) begin
        wrap_next = wrap + 16'd1;
      end
      hs_next  = s;
      rcv_next = rcv + 32'd1;
      acc      = 1'b1;
      status   = ST_IN_ORDER;
    end else if (jump_zone) begin
      if ({1'b0, s} == ebs) begin
        base_next = 16'(s);
        hs_next   = s - SB'(1);
        ebs_next  = EBS_NEVER;
        wrap_next = '0;
        rcv_next  = 32'd1;
        prob_next = min_sequential;
        acc       = 1'b1;
        status    = ST_RESYNC;
      end else begin
        ebs_next = {1'b0, s_inc};
        status   = ST_JUMP;
      end
    end else begin
      rcv_next = rcv + 32'd1;
      acc      = 1'b1;
      status   = ST_REORDER;
    end

    res.accepted        = acc;
    res.status          = status;
    res.ext_highest_seq = 32'({wrap_next, hs_next});
    res.received_count  = rcv_next;
    res.base_sequence   = base_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prob <= '0;
      hs   <= '0;
      ebs  <= EBS_NEVER;
      wrap <= '0;
      rcv  <= '0;
      base <= '0;
    end else if (item_take) begin
      prob <= prob_next;
      hs   <= hs_next;
      ebs  <= ebs_next;
      wrap <= wrap_next;
      rcv  <= rcv_next;
      base <= base_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/rtp_sequence_tracker_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_sequence_tracker_unit: RTP sequence number validation, one source
// Input queue: push/full carrying cmd and seq (start a source, or a packet).
// Result queue: empty/pop carrying accepted, status, ext_highest_seq,
// received_count and base_sequence; one result beat per input beat, in order.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; always
// ready; it is to be written only while no items are in flight (user's duty).
// Result path: the core reads the item at the head of the input queue and
// computes its result combinationally; the result is written into the result
// queue as its input beat is taken.
// Throughput: one item per cycle while the result queue has room, set by the
// state update in the core, which reads the state left by the previous item.
// Reset (rst, synchronous): queues empty, source state cleared, expected
// jump target set to a value no sequence number matches, configuration
// back to min_sequential 2, max_dropout 3000, max_misorder 100.
// Receiver stall: the two-entry result queue fills, the core holds, the
// two-entry input queue fills, and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module rtp_sequence_tracker_unit
  import rtpst_pkg::*;
#(
  parameter int SEQ_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [15:0] seq,
  output logic             empty,
  input  wire logic        pop,
  output logic             accepted,
  output logic [2:0]       status,
  output logic [31:0]      ext_highest_seq,
  output logic [31:0]      received_count,
  output logic [15:0]      base_sequence,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res_in;
  result_t res_out;
  logic    res_push;
  logic    res_full;

  assign cfg_ready = 1'b1;

  rtpst_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .seq        (seq),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rtpst_core #(
    .SEQ_BITS (SEQ_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_push   (res_push),
    .res        (res_in),
    .res_full   (res_full)
  );

  rtpst_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (2)
  ) u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign accepted        = res_out.accepted;
  assign status          = res_out.status;
  assign ext_highest_seq = res_out.ext_highest_seq;
  assign received_count  = res_out.received_count;
  assign base_sequence   = res_out.base_sequence;

endmodule

`default_nettype wire
